/* rtl/core/argb_source_over_blend_clip_unit_macros.svh */
// Assertion macros shared by the compositor RTL.
`ifndef ARGB_SOURCE_OVER_BLEND_CLIP_UNIT_MACROS_SVH
`define ARGB_SOURCE_OVER_BLEND_CLIP_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off during reset.
`define ASOBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, held off during reset.
`define ASOBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define ASOBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASOBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/asobc_pkg.sv */
// Shared types, constants and divide-by-255 helpers for the compositor.
`timescale 1ns / 1ps
`default_nettype none

package asobc_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int CFG_IDX_W = 3;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLACE_X       = 3'd0,
        CFG_PLACE_Y       = 3'd1,
        CFG_TARGET_WIDTH  = 3'd2,
        CFG_TARGET_HEIGHT = 3'd3,
        CFG_LAYER_WIDTH   = 3'd4,
        CFG_LAYER_HEIGHT  = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_DROP  = 2'd0,
        KIND_COPY  = 2'd1,
        KIND_BLEND = 2'd2
    } kind_t;

    typedef struct packed {
        logic [DIM_W-1:0] place_x;
        logic [DIM_W-1:0] place_y;
        logic [DIM_W-1:0] target_width;
        logic [DIM_W-1:0] target_height;
        logic [DIM_W-1:0] layer_width;
        logic [DIM_W-1:0] layer_height;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        src_pixel;
        logic [31:0]        under_pixel;
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] src_row;
    } in_req_t;

    typedef struct packed {
        logic               write_flag;
        logic [COORD_W-1:0] target_col;
        logic [COORD_W-1:0] target_row;
        logic [31:0]        new_pixel;
    } out_req_t;

    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] target_col;
        logic [COORD_W-1:0] target_row;
        logic [31:0]        src_pixel;
        logic [31:0]        under_pixel;
    } q_entry_t;

    // Sizes above MAX_DIM behave as MAX_DIM.
    function automatic logic [DIM_W-1:0] cap_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

    // First guess of x/255: x/256 * (1 + 1/256 + 1/65536). Low by at most one.
    function automatic logic [16:0] div255_est(input logic [23:0] x);
        logic [24:0] sum;
        sum = 25'(x) + 25'(x[23:8]) + 25'(x[23:16]);
        return sum[24:8];
    endfunction

    // Fix the guess with one remainder compare.
    function automatic logic [16:0] div255_fix(input logic [23:0] x, input logic [16:0] q0);
        logic [25:0] r;
        r = 26'(x) + 26'(q0) - {1'b0, q0, 8'd0};
        return (r >= 26'd255) ? q0 + 17'd1 : q0;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/argb_source_over_blend_clip_unit.sv */
// Top level of the ARGB8888 source-over compositor with placement and clipping.
// Throughput: one request per cycle while in_stall is low; the 4-entry queue absorbs output stalls until it fills.
// Path: an accepted request passes the front register, a queue slot, five blend stages
// and the output register.
// Reset: asynchronous, active low; clears the configuration, queue pointers and valid bits
// and empties the pipe; payload registers keep no reset value.
`timescale 1ns / 1ps
`default_nettype none

module argb_source_over_blend_clip_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [asobc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [asobc_pkg::DIM_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  asobc_pkg::in_req_t                   in_req,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output asobc_pkg::out_req_t                  out_req
);
    import asobc_pkg::*;

    // Configuration registers; the user must write them only while the unit is idle; the unit does not enforce this.
    cfg_t     cfg_reg;
    cfg_t     cfg_next;

    // Front end to queue.
    logic     push;
    q_entry_t push_data;
    logic     q_full;

    // Queue to back end.
    logic     pop;
    q_entry_t pop_data;
    logic     q_empty;

    // Decode a register write; indexes past the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_PLACE_X:       cfg_next.place_x       = cfg_data;
                CFG_PLACE_Y:       cfg_next.place_y       = cfg_data;
                CFG_TARGET_WIDTH:  cfg_next.target_width  = cfg_data;
                CFG_TARGET_HEIGHT: cfg_next.target_height = cfg_data;
                CFG_LAYER_WIDTH:   cfg_next.layer_width   = cfg_data;
                CFG_LAYER_HEIGHT:  cfg_next.layer_height  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Place, clip and classify each request; hold it until the queue has room.
    asobc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // Decouple classification from the blend pipe.
    asobc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // Blend, copy or drop, and drive the result register.
    asobc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_req   (out_req)
    );

endmodule

`default_nettype wire

/* rtl/core/asobc_front.sv */
// Front end: take requests, place and clip them, classify as drop, copy or blend.
`timescale 1ns / 1ps
`default_nettype none

module asobc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  asobc_pkg::cfg_t    cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  asobc_pkg::in_req_t in_req,
    output logic               push,
    output asobc_pkg::q_entry_t push_data,
    input  logic               q_full
);
    import asobc_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    q_entry_t          entry_reg;
    q_entry_t          entry_next;
    logic              load;
    logic signed [13:0] dx;
    logic signed [13:0] dy;
    logic              keep;
    logic [7:0]        sa;

    assign push      = valid_reg && !q_full;
    assign in_stall  = valid_reg && q_full;
    assign load      = in_valid && !in_stall;
    assign push_data = entry_reg;

    always_comb
    begin
        dx = $signed({cfg.place_x[DIM_W-1], cfg.place_x}) + $signed({2'b00, in_req.src_col});
        dy = $signed({cfg.place_y[DIM_W-1], cfg.place_y}) + $signed({2'b00, in_req.src_row});
        sa = in_req.src_pixel[31:24];

        keep = ({1'b0, in_req.src_col} < cap_dim(cfg.layer_width))
            && ({1'b0, in_req.src_row} < cap_dim(cfg.layer_height))
            && !dx[13] && (dx[12:0] < cap_dim(cfg.target_width))
            && !dy[13] && (dy[12:0] < cap_dim(cfg.target_height))
            && (sa != 8'd0);

        entry_next.target_col  = dx[COORD_W-1:0];
        entry_next.target_row  = dy[COORD_W-1:0];
        entry_next.src_pixel   = in_req.src_pixel;
        entry_next.under_pixel = in_req.under_pixel;
        if (!keep)
        begin
            entry_next.kind = KIND_DROP;
        end
        else if (sa == 8'hFF)
        begin
            entry_next.kind = KIND_COPY;
        end
        else
        begin
            entry_next.kind = KIND_BLEND;
        end

        valid_next = load || (valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/asobc_queue.sv */
// Small register queue between the front end and the blend pipeline.
`timescale 1ns / 1ps
`default_nettype none

`include "argb_source_over_blend_clip_unit_macros.svh"

module asobc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  asobc_pkg::q_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output asobc_pkg::q_entry_t pop_data,
    output logic                empty
);
    import asobc_pkg::*;

    q_entry_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASOBC_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full)
    `ASOBC_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, !empty)
    `ASOBC_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

`default_nettype wire

/* rtl/core/asobc_back.sv */
// Back end: source-over blend pipeline with an output register.
`timescale 1ns / 1ps
`default_nettype none

`include "argb_source_over_blend_clip_unit_macros.svh"

module asobc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  asobc_pkg::q_entry_t pop_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output asobc_pkg::out_req_t out_req
);
    import asobc_pkg::*;

    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [31:0]        src;
    } tag_t;

    typedef struct packed {
        tag_t             tag;
        logic [7:0]       sa;
        logic [2:0][7:0]  cd;
        logic [2:0][15:0] m;
        logic [15:0]      t;
    } s1_t;

    typedef struct packed {
        tag_t             tag;
        logic [7:0]       sa;
        logic [2:0][15:0] m;
        logic [2:0][23:0] p;
        logic [15:0]      xa;
        logic [16:0]      qa0;
    } s2_t;

    typedef struct packed {
        tag_t             tag;
        logic [7:0]       oa;
        logic [2:0][15:0] m;
        logic [2:0][23:0] p;
        logic [2:0][16:0] qc0;
    } s3_t;

    typedef struct packed {
        tag_t             tag;
        logic [7:0]       oa;
        logic [2:0][16:0] y;
    } s4_t;

    typedef struct packed {
        tag_t             tag;
        logic [7:0]       oa;
        logic [2:0][16:0] y;
        logic [2:0][16:0] yq0;
    } s5_t;

    logic       adv;
    logic [4:0] v_reg;
    logic [4:0] v_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    s1_t        s1_reg, s1_next;
    s2_t        s2_reg, s2_next;
    s3_t        s3_reg, s3_next;
    s4_t        s4_reg, s4_next;
    s5_t        s5_reg, s5_next;
    out_req_t   out_reg, out_next;
    logic [16:0] qa;
    logic [16:0] qc;
    logic [2:0][7:0] ch;
    logic [7:0] inv;

    // Whole pipe freezes only when a finished result is held back.
    assign adv       = !(out_valid_reg && out_stall);
    assign pop       = adv && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_req   = out_reg;

    always_comb
    begin
        // Stage 1: alpha product and source products.
        inv = 8'hFF - pop_data.src_pixel[31:24];
        s1_next.tag.kind = pop_data.kind;
        s1_next.tag.col  = pop_data.target_col;
        s1_next.tag.row  = pop_data.target_row;
        s1_next.tag.src  = pop_data.src_pixel;
        s1_next.sa       = pop_data.src_pixel[31:24];
        s1_next.t        = 16'(pop_data.under_pixel[31:24]) * 16'(inv);
        for (int c = 0; c < 3; c++)
        begin
            s1_next.cd[c] = pop_data.under_pixel[8*c +: 8];
            s1_next.m[c]  = 16'(pop_data.src_pixel[8*c +: 8]) * 16'(pop_data.src_pixel[31:24]);
        end

        // Stage 2: destination products, first guess of the alpha quotient.
        s2_next.tag = s1_reg.tag;
        s2_next.sa  = s1_reg.sa;
        s2_next.m   = s1_reg.m;
        s2_next.xa  = s1_reg.t + 16'd127;
        s2_next.qa0 = div255_est(24'(s1_reg.t + 16'd127));
        for (int c = 0; c < 3; c++)
        begin
            s2_next.p[c] = 24'(s1_reg.cd[c]) * 24'(s1_reg.t);
        end

        // Stage 3: settle alpha, guess destination terms.
        qa = div255_fix(24'(s2_reg.xa), s2_reg.qa0);
        s3_next.tag = s2_reg.tag;
        s3_next.oa  = s2_reg.sa + qa[7:0];
        s3_next.m   = s2_reg.m;
        s3_next.p   = s2_reg.p;
        for (int c = 0; c < 3; c++)
        begin
            s3_next.qc0[c] = div255_est(s2_reg.p[c]);
        end

        // Stage 4: settle destination terms, form the rounded sums.
        s4_next.tag = s3_reg.tag;
        s4_next.oa  = s3_reg.oa;
        for (int c = 0; c < 3; c++)
        begin
            qc = div255_fix(s3_reg.p[c], s3_reg.qc0[c]);
            s4_next.y[c] = 17'(s3_reg.m[c]) + qc + 17'd127;
        end

        // Stage 5: guess the final quotients.
        s5_next.tag = s4_reg.tag;
        s5_next.oa  = s4_reg.oa;
        s5_next.y   = s4_reg.y;
        for (int c = 0; c < 3; c++)
        begin
            s5_next.yq0[c] = div255_est(24'(s4_reg.y[c]));
        end

        // Output: settle and assemble.
        for (int c = 0; c < 3; c++)
        begin
            ch[c] = 8'(div255_fix(24'(s5_reg.y[c]), s5_reg.yq0[c]));
        end
        out_next = '0;
        case (s5_reg.tag.kind)
            KIND_COPY:
            begin
                out_next.write_flag = 1'b1;
                out_next.target_col = s5_reg.tag.col;
                out_next.target_row = s5_reg.tag.row;
                out_next.new_pixel  = s5_reg.tag.src;
            end
            KIND_BLEND:
            begin
                out_next.write_flag = 1'b1;
                out_next.target_col = s5_reg.tag.col;
                out_next.target_row = s5_reg.tag.row;
                out_next.new_pixel  = {s5_reg.oa, ch[2], ch[1], ch[0]};
            end
            default:
            begin
                out_next = '0;
            end
        endcase

        v_next         = {v_reg[3:0], pop};
        out_valid_next = v_reg[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            s5_reg  <= s5_next;
            out_reg <= out_next;
        end
    end

    `ASOBC_ASSERT_IMPLY(a_drop_is_zero, clk, rst_n, out_valid_reg && !out_reg.write_flag, out_reg.new_pixel == '0 && out_reg.target_col == '0 && out_reg.target_row == '0)

endmodule

`default_nettype wire
